>>> rtl/core/metric_clock_modulator_defines.svh
// Assertion macros for the metric clock modulator.
// Used by metric_clock_modulator.sv; expects clk and arst_n in scope.
`ifndef METRIC_CLOCK_MODULATOR_DEFINES_SVH
`define METRIC_CLOCK_MODULATOR_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define MCM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MCM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mcm_pkg.sv
// Shared constants and helpers for the metric clock modulator.
// No dependencies.
package mcm_pkg;
	localparam int PHASE_BITS_DEF = 16;
	localparam int MAX_BEATS      = 16;
	localparam int BEAT_CAP       = (MAX_BEATS < 31) ? MAX_BEATS : 31;
	localparam int COUNT_W        = 5;
	localparam int TEMPO_W        = 16;
	// divisor width: a tempo part times a count
	localparam int DEN_W          = TEMPO_W + COUNT_W;

	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = COUNT_W'(1);
		else if (v > COUNT_W'(BEAT_CAP))
			r = COUNT_W'(BEAT_CAP);
		return r;
	endfunction
endpackage

>>> rtl/core/mcm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mcm_pkg.
module mcm_div
	import mcm_pkg::*;
#(
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

>>> rtl/core/metric_clock_modulator.sv
// Metric clock modulator top level: sequencer, state and result register.
// Depends on mcm_pkg, mcm_div and metric_clock_modulator_defines.svh.
//
// One transaction in carries a root clock phase sample plus controls; one
// transaction out carries four gates, two flags and the effective beats and
// subdivisions. All divisions, remainders and the gcd of a modulation run
// through one shared restoring divider (NUM_W = 32 + PHASE_BITS bits, one
// bit a cycle). An ordinary item takes three divisions from acceptance to the
// result register; a root wrap adds one division, and a measure step adds
// one more. A modulation adds one division per gcd step (at most about 30)
// and two more to reduce the fraction. in_stall is high from acceptance
// until the result is loaded into the output register; the next transaction
// can be taken while that result still waits.
`include "metric_clock_modulator_defines.svh"
module metric_clock_modulator
	import mcm_pkg::*;
#(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        root_phase,
	input  logic [COUNT_W-1:0] beats_request,
	input  logic [COUNT_W-1:0] subdivisions_request,
	input  logic               tempo_reset,
	input  logic               metric_modulation,
	input  logic               round_trip,
	input  logic               invert_request,
	input  logic               latch_at_downbeat,
	input  logic [15:0]        pulse_width,
	input  logic [15:0]        phase_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               beat_gate,
	output logic               downbeat_gate,
	output logic               subdivision_gate,
	output logic               shifted_gate,
	output logic               modulate_flag,
	output logic               invert_taken,
	output logic [COUNT_W-1:0] beats_now,
	output logic [COUNT_W-1:0] subdivisions_now
);
	localparam int PB    = PHASE_BITS;
	localparam int NUM_W = 32 + PB;
	localparam int SH_L  = (PB >= 16) ? PB - 16 : 0;
	localparam int SH_R  = (PB >= 16) ? 0 : 16 - PB;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WRAP, ST_WRAP_W, ST_MUL, ST_SCALE_W, ST_MBC_W, ST_LATCH,
		ST_FRAC, ST_GCD, ST_GCD_W, ST_RN_W, ST_RD_W, ST_MAPPLY, ST_INV,
		ST_FIN, ST_DB_W, ST_SD_W, ST_OUT
	} state_t;

	function automatic logic [PB-1:0] to_phase(input logic [15:0] x);
		logic [PB+15:0] w;
		w = ((PB + 16)'(x) << SH_L) >> SH_R;
		return w[PB-1:0];
	endfunction

	state_t state_q;

	// captured transaction
	logic [PB-1:0]      rp_q, pw_q, off_q;
	logic [COUNT_W-1:0] b_q, s_q;
	logic               rst_q, mm_q, rt_q, inv_q, lad_q;

	// persistent state
	logic [PB:0]        last_root_q, last_scaled_q;
	logic [TEMPO_W-1:0] rwc_q, tempo_mul_q, tempo_div_q, saved_mul_q, saved_div_q;
	logic [COUNT_W-1:0] mbc_q, beats_held_q, subs_held_q;
	logic               mod_lock_q, inv_lock_q;

	// working values
	logic [PB-1:0]      scaled_q;
	logic [DEN_W-1:0]   n_q, d_q, gx_q, gy_q;
	logic               modflag_q, taken_q, db_q;

	// result register
	logic               out_valid_q;
	logic               beat_q, down_q, sub_q, shift_q, oflag_q, otaken_q;
	logic [COUNT_W-1:0] obeats_q, osubs_q;

	// divider
	logic               div_start_q, div_done;
	logic [NUM_W-1:0]   div_num_q, div_quot;
	logic [DEN_W-1:0]   div_den_q, div_rem;

	logic [DEN_W-1:0]   bh_den;
	logic [PB-1:0]      shifted_sum;

	assign bh_den      = DEN_W'(beats_held_q);
	assign shifted_sum = scaled_q + off_q;
	assign in_stall    = (state_q != ST_IDLE);

	mcm_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_root_q   <= (PB + 1)'(1) << PB;
			last_scaled_q <= (PB + 1)'(1) << PB;
			rwc_q         <= '0;
			mbc_q         <= '0;
			tempo_mul_q   <= TEMPO_W'(1);
			tempo_div_q   <= TEMPO_W'(1);
			saved_mul_q   <= TEMPO_W'(1);
			saved_div_q   <= TEMPO_W'(1);
			beats_held_q  <= COUNT_W'(1);
			subs_held_q   <= '0;
			mod_lock_q    <= 1'b0;
			inv_lock_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			div_start_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rp_q      <= to_phase(root_phase);
						pw_q      <= to_phase(pulse_width);
						off_q     <= to_phase(phase_offset);
						b_q       <= clamp_count(beats_request);
						s_q       <= clamp_count(subdivisions_request);
						rst_q     <= tempo_reset;
						mm_q      <= metric_modulation;
						rt_q      <= round_trip;
						inv_q     <= invert_request;
						lad_q     <= latch_at_downbeat;
						modflag_q <= 1'b0;
						taken_q   <= 1'b0;
						state_q   <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					last_root_q <= {1'b0, rp_q};
					if (last_root_q > {1'b0, rp_q}) begin
						div_num_q   <= NUM_W'(rwc_q) + NUM_W'(1);
						div_den_q   <= DEN_W'(tempo_div_q);
						div_start_q <= 1'b1;
						state_q     <= ST_WRAP_W;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_WRAP_W: begin
					if (div_done) begin
						rwc_q   <= div_rem[TEMPO_W-1:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// (wraps * ONE + root) * tempo_mul, divided by tempo_div next
					div_num_q   <= NUM_W'({rwc_q, rp_q}) * NUM_W'(tempo_mul_q);
					div_den_q   <= DEN_W'(tempo_div_q);
					div_start_q <= 1'b1;
					state_q     <= ST_SCALE_W;
				end
				ST_SCALE_W: begin
					if (div_done) begin
						scaled_q <= div_quot[PB-1:0];
						if (last_scaled_q > {1'b0, div_quot[PB-1:0]}) begin
							div_num_q   <= NUM_W'(mbc_q) + NUM_W'(1);
							div_den_q   <= bh_den;
							div_start_q <= 1'b1;
							state_q     <= ST_MBC_W;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MBC_W: begin
					if (div_done) begin
						mbc_q   <= div_rem[COUNT_W-1:0];
						state_q <= ST_LATCH;
					end
				end
				ST_LATCH: begin
					if (lad_q && mbc_q != '0) begin
						state_q <= ST_FIN;
					end else begin
						beats_held_q <= b_q;
						subs_held_q  <= s_q;
						if (rst_q) begin
							tempo_mul_q <= TEMPO_W'(1);
							tempo_div_q <= TEMPO_W'(1);
						end
						if (mm_q && !mod_lock_q) begin
							state_q <= ST_FRAC;
						end else begin
							if (rt_q) begin
								if (!mm_q) begin
									tempo_mul_q <= saved_mul_q;
									tempo_div_q <= saved_div_q;
								end
								modflag_q <= 1'b1;
							end
							state_q <= ST_INV;
						end
					end
				end
				ST_FRAC: begin
					n_q     <= DEN_W'(tempo_mul_q) * DEN_W'(s_q);
					d_q     <= DEN_W'(tempo_div_q) * DEN_W'(b_q);
					gx_q    <= DEN_W'(tempo_mul_q) * DEN_W'(s_q);
					gy_q    <= DEN_W'(tempo_div_q) * DEN_W'(b_q);
					state_q <= ST_GCD;
				end
				ST_GCD: begin
					div_start_q <= 1'b1;
					if (gy_q == '0) begin
						div_num_q <= NUM_W'(n_q);
						div_den_q <= gx_q;
						state_q   <= ST_RN_W;
					end else begin
						div_num_q <= NUM_W'(gx_q);
						div_den_q <= gy_q;
						state_q   <= ST_GCD_W;
					end
				end
				ST_GCD_W: begin
					if (div_done) begin
						gx_q    <= gy_q;
						gy_q    <= div_rem;
						state_q <= ST_GCD;
					end
				end
				ST_RN_W: begin
					if (div_done) begin
						n_q         <= div_quot[DEN_W-1:0];
						div_num_q   <= NUM_W'(d_q);
						div_den_q   <= gx_q;
						div_start_q <= 1'b1;
						state_q     <= ST_RD_W;
					end
				end
				ST_RD_W: begin
					if (div_done) begin
						d_q     <= div_quot[DEN_W-1:0];
						state_q <= ST_MAPPLY;
					end
				end
				ST_MAPPLY: begin
					// oversized reduced fraction: modulation refused
					if (n_q[DEN_W-1:TEMPO_W] == '0 && d_q[DEN_W-1:TEMPO_W] == '0) begin
						if (rt_q) begin
							saved_mul_q <= tempo_mul_q;
							saved_div_q <= tempo_div_q;
						end
						tempo_mul_q <= n_q[TEMPO_W-1:0];
						tempo_div_q <= d_q[TEMPO_W-1:0];
						mod_lock_q  <= 1'b1;
						subs_held_q <= beats_held_q;
						s_q         <= beats_held_q;
						modflag_q   <= 1'b1;
					end
					state_q <= ST_INV;
				end
				ST_INV: begin
					if (inv_q && !inv_lock_q) begin
						taken_q      <= 1'b1;
						beats_held_q <= s_q;
						subs_held_q  <= b_q;
						inv_lock_q   <= 1'b1;
						b_q          <= s_q;
						s_q          <= b_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!mm_q)
						mod_lock_q <= 1'b0;
					if (!(inv_q && !taken_q))
						inv_lock_q <= 1'b0;
					last_scaled_q <= {1'b0, scaled_q};
					div_num_q     <= NUM_W'({mbc_q, scaled_q});
					div_den_q     <= bh_den;
					div_start_q   <= 1'b1;
					state_q       <= ST_DB_W;
				end
				ST_DB_W: begin
					if (div_done) begin
						db_q        <= div_quot < NUM_W'(pw_q);
						div_num_q   <= NUM_W'({mbc_q, scaled_q}) * NUM_W'(subs_held_q);
						div_den_q   <= bh_den;
						div_start_q <= 1'b1;
						state_q     <= ST_SD_W;
					end
				end
				ST_SD_W: begin
					if (div_done) begin
						sub_q   <= div_quot[PB-1:0] < pw_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						beat_q      <= scaled_q < pw_q;
						down_q      <= db_q;
						shift_q     <= shifted_sum < pw_q;
						oflag_q     <= modflag_q;
						otaken_q    <= taken_q;
						obeats_q    <= b_q;
						osubs_q     <= s_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign beat_gate        = beat_q;
	assign downbeat_gate    = down_q;
	assign subdivision_gate = sub_q;
	assign shifted_gate     = shift_q;
	assign modulate_flag    = oflag_q;
	assign invert_taken     = otaken_q;
	assign beats_now        = obeats_q;
	assign subdivisions_now = osubs_q;

	// tempo parts never reach zero, so no division by zero
	`MCM_ASSERT_ALWAYS(a_tempo_nonzero, tempo_div_q != '0 && tempo_mul_q != '0, "tempo part is zero")
	`MCM_ASSERT_ALWAYS(a_beats_range, beats_held_q != '0 && beats_held_q <= COUNT_W'(BEAT_CAP), "held beats out of range")
	`MCM_ASSERT_ALWAYS(a_mbc_range, mbc_q < COUNT_W'(BEAT_CAP), "measure count out of range")
	`MCM_ASSERT_IMP(a_gcd_start, state_q == ST_GCD, !div_start_q && gx_q != '0, "gcd step with stale divider")
endmodule
